// ----- rtl/core/random_cell_time_pattern_top_defines.svh -----
// Assertion macros for the random cell time pattern block.
// Needs clk and rst in the scope of the module that uses them.
`ifndef RANDOM_CELL_TIME_PATTERN_TOP_DEFINES_SVH
`define RANDOM_CELL_TIME_PATTERN_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define RCTP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its condition.
`define RCTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rctp_pkg.sv -----
// Shared types, constants and digit helpers for the random cell time pattern block.
// No dependencies; used by random_cell_time_pattern_top.
package rctp_pkg;

  // Cell counts of the digit fields
  localparam int MaxCells  = 9;
  localparam int TensCells = (6 < MaxCells) ? 6 : MaxCells;
  localparam int CellIdxW  = $clog2(MaxCells);

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgSeedInit = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgUse24h   = CfgIdxW'(1);

  // Generator constants
  localparam logic [31:0] SeedReset  = 32'd100;
  localparam logic [17:0] LcgMul     = 18'd214013;
  localparam logic [31:0] LcgAdd     = 32'd2531011;
  localparam int          LcgShift   = 16;
  localparam int          SeedKeepW  = 15;

  // Reciprocals for the remainder: q = (x * Recip) >> RecipShift is exact for 15-bit x
  localparam int          RecipShift = 18;
  localparam logic [17:0] RecipUnits = 18'(((2 ** RecipShift) + MaxCells - 1) / MaxCells);
  localparam logic [17:0] RecipTens  = 18'(((2 ** RecipShift) + TensCells - 1) / TensCells);

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } rctp_in_t;

  typedef struct packed {
    logic [5:0] hour_tens_mask;
    logic [8:0] hour_units_mask;
    logic [5:0] minute_tens_mask;
    logic [8:0] minute_units_mask;
  } rctp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FILL,
    ST_DRAW,
    ST_MODR,
    ST_SWAP,
    ST_FIN,
    ST_GRD,
    ST_GACC,
    ST_NEXT,
    ST_DONE
  } rctp_state_t;

  // Hour as displayed: as is in 24-hour form, else 1..12
  function automatic logic [4:0] shown_hour(input logic [4:0] hour, input logic use_24h);
    logic [4:0] h;
    h = hour;
    if (!use_24h) begin
      if (hour >= 5'd24) begin
        h = hour - 5'd24;
      end else if (hour >= 5'd12) begin
        h = hour - 5'd12;
      end
      if (h == 5'd0) begin
        h = 5'd12;
      end
    end
    return h;
  endfunction

  // Tens digit of a value below 64
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  // Units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] tens_val;
    tens_val = 6'(tens_of(v)) * 6'd10;
    return 4'(v - tens_val);
  endfunction

endpackage

// ----- rtl/core/random_cell_time_pattern_top.sv -----
// Per nonzero digit: fill the cell order, draw, reduce and swap per cell, finish the last
// swap, then gather the lit cells up to two at a time; a zero digit is skipped. A new time is
// taken only once the previous result is in the output register; the pace is set by the
// shared multiplier and the single write port of the cell-order memory. A finished result
// waits in an output register. Reset (rst, synchronous): generator seed 100, 24-hour form,
// no result pending. Depends on rctp_pkg and random_cell_time_pattern_top_defines.svh.
`include "random_cell_time_pattern_top_defines.svh"

module random_cell_time_pattern_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rctp_pkg::rctp_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rctp_pkg::rctp_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [rctp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rctp_pkg::CfgDataW-1:0] cfg_data
);
  import rctp_pkg::*;

  rctp_state_t state;
  rctp_state_t state_next;

  logic [31:0]          seed;
  logic                 use_24h;
  logic [3:0]           digit [4];
  logic [1:0]           dsel;
  logic [CellIdxW-1:0]  idx;
  logic [CellIdxW-1:0]  r_sel;
  logic [CellIdxW-1:0]  rd0;
  logic [CellIdxW-1:0]  rd1;
  logic [MaxCells-1:0]  mask;
  rctp_out_t            res;

  // Cell-order memory
  logic [CellIdxW-1:0]  order_mem [MaxCells];
  logic                 mem_we;
  logic [CellIdxW-1:0]  mem_wa;
  logic [CellIdxW-1:0]  mem_wd;
  logic                 rd_en;
  logic [CellIdxW-1:0]  ra0;
  logic [CellIdxW-1:0]  ra1;

  // Shared multiplier
  logic [31:0]          mul_a;
  logic [17:0]          mul_b;
  logic [31:0]          mul_p;
  logic [31:0]          lcg_sum;
  logic [31:0]          seed_next;
  logic [SeedKeepW-1:0] mod_x;
  logic [SeedKeepW-1:0] mod_q;
  logic [SeedKeepW-1:0] mod_qc;
  logic [CellIdxW-1:0]  mod_r;

  // Per-digit figures
  logic                 is_units;
  logic [3:0]           cur_digit;
  logic [3:0]           cur_cells;
  logic [3:0]           cur_lit;
  logic [CellIdxW-1:0]  cur_last;
  logic [CellIdxW:0]    idx_inc;
  logic [4:0]           idx_add2;
  logic                 in_xfer;
  logic                 out_free;
  logic [4:0]           hour_shown;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign hour_shown = shown_hour(in_data.hour, use_24h);

  assign is_units  = dsel[0];
  assign cur_digit = digit[dsel];
  assign cur_cells = is_units ? 4'(MaxCells) : 4'(TensCells);
  assign cur_lit   = (cur_digit > cur_cells) ? cur_cells : cur_digit;
  assign cur_last  = is_units ? CellIdxW'(MaxCells - 1) : CellIdxW'(TensCells - 1);
  assign idx_inc   = (CellIdxW + 1)'(idx) + (CellIdxW + 1)'(1);
  assign idx_add2  = 5'(idx) + 5'd2;

  // Shared multiplier: generator step in DRAW, reciprocal for the remainder otherwise
  assign mul_p     = 32'(mul_a * mul_b);
  assign lcg_sum   = mul_p + LcgAdd;
  assign seed_next = 32'(lcg_sum[LcgShift +: SeedKeepW]);
  assign mod_x     = seed[SeedKeepW-1:0];
  assign mod_q     = SeedKeepW'(mul_p >> RecipShift);
  assign mod_qc    = is_units ? SeedKeepW'(mod_q * MaxCells) : SeedKeepW'(mod_q * TensCells);
  assign mod_r     = CellIdxW'(mod_x - mod_qc);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_START;
      ST_START: state_next = (cur_digit == 4'd0) ? ST_NEXT : ST_FILL;
      ST_FILL:  if (idx == cur_last) state_next = ST_DRAW;
      ST_DRAW:  state_next = ST_MODR;
      ST_MODR:  state_next = ST_SWAP;
      ST_SWAP:  state_next = (idx == cur_last) ? ST_FIN : ST_DRAW;
      ST_FIN:   state_next = ST_GRD;
      ST_GRD:   state_next = ST_GACC;
      ST_GACC:  state_next = (idx_add2 >= 5'(cur_lit)) ? ST_NEXT : ST_GRD;
      ST_NEXT:  state_next = (dsel == 2'd3) ? ST_DONE : ST_START;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory and multiplier controls
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = idx;
    rd_en  = 1'b0;
    ra0    = idx;
    ra1    = r_sel;
    mul_a  = {{(32 - SeedKeepW){1'b0}}, mod_x};
    mul_b  = is_units ? RecipUnits : RecipTens;
    unique case (state)
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_DRAW: begin
        // finish the previous swap while the multiplier steps the generator
        mul_a  = seed;
        mul_b  = LcgMul;
        mem_we = (idx != '0);
        mem_wa = r_sel;
        mem_wd = rd0;
      end
      ST_MODR: begin
        rd_en = 1'b1;
        ra1   = mod_r;
      end
      ST_SWAP: begin
        mem_we = 1'b1;
        mem_wd = rd1;
      end
      ST_FIN: begin
        mem_we = 1'b1;
        mem_wa = r_sel;
        mem_wd = rd0;
      end
      ST_GRD: begin
        rd_en = 1'b1;
        ra1   = (idx_inc > (CellIdxW + 1)'(cur_last)) ? idx : CellIdxW'(idx_inc);
      end
      default: begin
      end
    endcase
  end

  // Cell-order memory, registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      order_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd0 <= order_mem[ra0];
      rd1 <= order_mem[ra1];
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= SeedReset;
      use_24h   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgSeedInit: seed    <= cfg_data;
          CfgUse24h:   use_24h <= cfg_data[0];
        endcase
      end else if (state == ST_DRAW) begin
        seed <= seed_next;
      end
      // drop the result once transferred, load a new one when the slot is free
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          digit[0] <= tens_of(6'(hour_shown));
          digit[1] <= units_of(6'(hour_shown));
          digit[2] <= tens_of(in_data.minute);
          digit[3] <= units_of(in_data.minute);
          dsel     <= 2'd0;
        end
      end
      ST_START: begin
        idx  <= '0;
        mask <= '0;
      end
      ST_FILL: begin
        idx <= (idx == cur_last) ? '0 : CellIdxW'(idx_inc);
      end
      ST_MODR: begin
        r_sel <= mod_r;
      end
      ST_SWAP: begin
        if (idx != cur_last) begin
          idx <= CellIdxW'(idx_inc);
        end
      end
      ST_FIN: begin
        idx <= '0;
      end
      ST_GACC: begin
        // gather up to two lit cells a pass
        mask <= mask | (MaxCells'(1) << rd0)
                     | (((CellIdxW + 1)'(idx_inc) < (CellIdxW + 1)'(cur_lit)) ?
                        (MaxCells'(1) << rd1) : '0);
        idx  <= CellIdxW'(idx_add2);
      end
      ST_NEXT: begin
        unique case (dsel)
          2'd0: res.hour_tens_mask    <= 6'(mask);
          2'd1: res.hour_units_mask   <= 9'(mask);
          2'd2: res.minute_tens_mask  <= 6'(mask);
          2'd3: res.minute_units_mask <= 9'(mask);
        endcase
        dsel <= dsel + 2'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

  // Swap partner always lies inside the current field
  `RCTP_ASSERT_SAME(a_mod_range, state == ST_MODR, mod_r <= cur_last, "swap index out of field")
  // A finished digit lights exactly its count of distinct cells
  `RCTP_ASSERT_SAME(a_lit_count, state == ST_NEXT, $countones(mask) == int'(cur_lit), "lit count wrong")
  // The generator keeps 15 bits after each step
  `RCTP_ASSERT_NEXT(a_seed_narrow, (state == ST_DRAW) && !cfg_we, seed[31:SeedKeepW] == '0, "seed too wide")
  // A result appears only out of the send state
  `RCTP_ASSERT_NEXT(a_out_source, !out_valid, !out_valid || $past(state == ST_DONE), "stray result")

endmodule
